@@ rtl/hwm_pkg.sv @@
`default_nettype none

package hwm_pkg;

   // Field widths
   localparam int CMD_W  = 16;   // Q8.8 command
   localparam int WHL_W  = 18;   // raw wheel sum, signed
   localparam int MAG_W  = 17;   // raw wheel magnitude
   localparam int LIM_W  = 15;   // speed limit in Q7.8
   localparam int NUM_W  = MAG_W + LIM_W;  // scale numerator
   localparam int QUO_W  = 15;   // scaled magnitude, at most the limit
   localparam int LWH_W  = 16;   // limited wheel, signed
   localparam int MV_W   = 15;   // wheel drive in millivolts
   localparam int APP_W  = 16;   // recovered drive signal
   localparam int PCT_W  = 7;    // speed limit in whole percent
   localparam int FRAC_W = 8;    // Q8.8 fraction bits

   localparam int NUM_WHEELS = 4;

   // Constants
   localparam int FULL_Q88   = 25600;   // 100 percent in Q8.8
   localparam int PCT_MAX    = 100;
   localparam int MV_PER_PCT = 120;
   localparam int MVP_W      = LWH_W - 1 + PCT_W;   // |wheel| * 120

   // Wheel order
   localparam int WHL_FL = 0;
   localparam int WHL_FR = 1;
   localparam int WHL_BL = 2;
   localparam int WHL_BR = 3;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_MODE  = 1'b1;

   // Limit modes
   localparam logic LIMIT_SCALE = 1'b0;
   localparam logic LIMIT_CLAMP = 1'b1;

endpackage

`default_nettype wire

@@ rtl/holonomic_wheel_mixer_core.sv @@
`default_nettype none

// Four-wheel mecanum / X-drive mixer. One command (forward, strafe, rotate)
// may be issued on every clock: busy stays low and start alone launches a
// request. Each request yields exactly one result, which is shown
// for one cycle with rsp_valid; the receiver must take it then, since
// results cannot be held back. The proportional scaling is a restoring
// divider, unrolled into 15 one-bit stages for all four
// wheels at once, framed by four stages in front (mix, magnitude and clamp,
// peak search, numerator multiply) and two behind (sign and select, drive
// and recovery). Write csr_* only while no request is in flight.
module holonomic_wheel_mixer_core
   import hwm_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  signed [CMD_W-1:0]      req_forward_cmd,
   input  wire  signed [CMD_W-1:0]      req_strafe_cmd,
   input  wire  signed [CMD_W-1:0]      req_rotate_cmd,
   output logic                         rsp_valid,
   output logic signed [MV_W-1:0]       rsp_front_left_mv,
   output logic signed [MV_W-1:0]       rsp_front_right_mv,
   output logic signed [MV_W-1:0]       rsp_back_left_mv,
   output logic signed [MV_W-1:0]       rsp_back_right_mv,
   output logic signed [APP_W-1:0]      rsp_applied_forward,
   output logic signed [APP_W-1:0]      rsp_applied_strafe,
   output logic signed [APP_W-1:0]      rsp_applied_rotate,
   input  wire                          csr_we,
   input  wire  [CSR_IDX_W-1:0]         csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int PIPE_DEPTH = 4 + QUO_W + 2;

   localparam logic signed [WHL_W-1:0] FULL_POS = WHL_W'(FULL_Q88);
   localparam logic signed [WHL_W-1:0] FULL_NEG = -WHL_W'(FULL_Q88);

   // Configuration
   logic [PCT_W-1:0] spd_lim_ff;
   logic             mode_ff;

   // Valid bits, one per stage
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   // Stage 1: mixed wheels
   logic signed [WHL_W-1:0] s1_whl_ff [NUM_WHEELS];
   logic signed [WHL_W-1:0] s1_whl_in [NUM_WHEELS];

   // Stage 2: magnitude, sign, clamped wheel, limit
   logic [MAG_W-1:0]        s2_mag_ff [NUM_WHEELS];
   logic [MAG_W-1:0]        s2_mag_in [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]   s2_neg_ff;
   logic [NUM_WHEELS-1:0]   s2_neg_in;
   logic signed [LWH_W-1:0] s2_alt_ff [NUM_WHEELS];
   logic signed [LWH_W-1:0] s2_alt_in [NUM_WHEELS];
   logic [LIM_W-1:0]        s2_lim_ff;
   logic [LIM_W-1:0]        s2_lim_in;

   // Stage 3: peak magnitude and scale decision
   logic [MAG_W-1:0]        s3_mag_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]   s3_neg_ff;
   logic signed [LWH_W-1:0] s3_alt_ff [NUM_WHEELS];
   logic [LIM_W-1:0]        s3_lim_ff;
   logic [MAG_W-1:0]        s3_max_ff;
   logic [MAG_W-1:0]        s3_max_in;
   logic                    s3_scale_ff;
   logic                    s3_scale_in;

   // Divider chain: index 0 is loaded by the numerator stage
   logic [NUM_W-1:0]        dv_rem_ff   [QUO_W+1][NUM_WHEELS];
   logic [NUM_W-1:0]        dv_rem_in   [QUO_W+1][NUM_WHEELS];
   logic [QUO_W-1:0]        dv_quo_ff   [QUO_W+1][NUM_WHEELS];
   logic [QUO_W-1:0]        dv_quo_in   [QUO_W+1][NUM_WHEELS];
   logic signed [LWH_W-1:0] dv_alt_ff   [QUO_W+1][NUM_WHEELS];
   logic [MAG_W-1:0]        dv_den_ff   [QUO_W+1];
   logic [NUM_WHEELS-1:0]   dv_neg_ff   [QUO_W+1];
   logic                    dv_scale_ff [QUO_W+1];

   // Limited wheels
   logic signed [LWH_W-1:0] s5_whl_ff [NUM_WHEELS];
   logic signed [LWH_W-1:0] s5_whl_in [NUM_WHEELS];

   // Output stage
   logic signed [MV_W-1:0]  mv_in [NUM_WHEELS];
   logic signed [APP_W-1:0] fwd_in;
   logic signed [APP_W-1:0] side_in;
   logic signed [APP_W-1:0] turn_in;

   // No stalls anywhere: a request is taken on every cycle
   assign busy = 1'b0;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spd_lim_ff <= PCT_W'(PCT_MAX);
         mode_ff    <= LIMIT_SCALE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_LIMIT: spd_lim_ff <= csr_wdata[PCT_W-1:0];
            CSR_LIMIT_MODE:  mode_ff    <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // Advance valid bits
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Mix commands into wheel speeds
   always_comb begin
      logic signed [WHL_W-1:0] f_x;
      logic signed [WHL_W-1:0] s_x;
      logic signed [WHL_W-1:0] r_x;
      f_x = WHL_W'(req_forward_cmd);
      s_x = WHL_W'(req_strafe_cmd);
      r_x = WHL_W'(req_rotate_cmd);
      s1_whl_in[WHL_FL] = f_x + s_x + r_x;
      s1_whl_in[WHL_FR] = f_x - s_x - r_x;
      s1_whl_in[WHL_BL] = f_x - s_x + r_x;
      s1_whl_in[WHL_BR] = f_x + s_x - r_x;
   end

   // Split into sign and magnitude, clamp to full scale, saturate the limit
   always_comb begin
      logic signed [WHL_W-1:0] abs_w;
      logic signed [WHL_W-1:0] sat_w;
      logic [PCT_W-1:0]        lim_pct;
      abs_w = '0;
      sat_w = '0;
      for (int l = 0; l < NUM_WHEELS; l++) begin
         s2_neg_in[l] = s1_whl_ff[l][WHL_W-1];
         abs_w        = s2_neg_in[l] ? -s1_whl_ff[l] : s1_whl_ff[l];
         s2_mag_in[l] = abs_w[MAG_W-1:0];
         if (s1_whl_ff[l] > FULL_POS) begin
            sat_w = FULL_POS;
         end else if (s1_whl_ff[l] < FULL_NEG) begin
            sat_w = FULL_NEG;
         end else begin
            sat_w = s1_whl_ff[l];
         end
         // Unscaled wheels in scale mode never exceed full scale
         s2_alt_in[l] = sat_w[LWH_W-1:0];
      end
      lim_pct   = (spd_lim_ff > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : spd_lim_ff;
      s2_lim_in = {lim_pct, FRAC_W'(0)};
   end

   // Find the peak magnitude and decide on scaling
   always_comb begin
      logic [MAG_W-1:0] m01;
      logic [MAG_W-1:0] m23;
      m01 = (s2_mag_ff[0] > s2_mag_ff[1]) ? s2_mag_ff[0] : s2_mag_ff[1];
      m23 = (s2_mag_ff[2] > s2_mag_ff[3]) ? s2_mag_ff[2] : s2_mag_ff[3];
      s3_max_in   = (m01 > m23) ? m01 : m23;
      s3_scale_in = (mode_ff == LIMIT_SCALE) && (s3_max_in > MAG_W'(s2_lim_ff));
   end

   // Numerator and one quotient bit per divider stage
   always_comb begin
      logic [NUM_W-1:0] trial;
      trial = '0;
      for (int l = 0; l < NUM_WHEELS; l++) begin
         dv_rem_in[0][l] = NUM_W'(s3_mag_ff[l]) * NUM_W'(s3_lim_ff);
         dv_quo_in[0][l] = '0;
      end
      for (int k = 0; k < QUO_W; k++) begin
         for (int l = 0; l < NUM_WHEELS; l++) begin
            trial = NUM_W'(dv_den_ff[k]) << (QUO_W - 1 - k);
            if (dv_rem_ff[k][l] >= trial) begin
               dv_rem_in[k+1][l] = dv_rem_ff[k][l] - trial;
               dv_quo_in[k+1][l] = {dv_quo_ff[k][l][QUO_W-2:0], 1'b1};
            end else begin
               dv_rem_in[k+1][l] = dv_rem_ff[k][l];
               dv_quo_in[k+1][l] = {dv_quo_ff[k][l][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // Restore sign of scaled wheels, else take the clamped wheel
   always_comb begin
      logic signed [LWH_W-1:0] q_x;
      q_x = '0;
      for (int l = 0; l < NUM_WHEELS; l++) begin
         q_x = LWH_W'(dv_quo_ff[QUO_W][l]);
         if (dv_scale_ff[QUO_W]) begin
            s5_whl_in[l] = dv_neg_ff[QUO_W][l] ? -q_x : q_x;
         end else begin
            s5_whl_in[l] = dv_alt_ff[QUO_W][l];
         end
      end
   end

   // Convert to millivolts and recover the drive signal
   always_comb begin
      logic                    neg;
      logic signed [LWH_W-1:0] abs_w;
      logic [MVP_W-1:0]        prod;
      logic signed [MV_W-1:0]  mv_mag;
      logic signed [LWH_W:0]   d_side;
      logic signed [LWH_W:0]   d_turn;
      logic signed [LWH_W:0]   h_side;
      logic signed [LWH_W:0]   h_turn;
      logic signed [LWH_W+1:0] fwd_x;
      neg    = 1'b0;
      abs_w  = '0;
      prod   = '0;
      mv_mag = '0;
      for (int l = 0; l < NUM_WHEELS; l++) begin
         neg    = s5_whl_ff[l][LWH_W-1];
         abs_w  = neg ? -s5_whl_ff[l] : s5_whl_ff[l];
         prod   = MVP_W'(abs_w[LWH_W-2:0]) * MVP_W'(MV_PER_PCT);
         mv_mag = MV_W'(prod[MVP_W-1:FRAC_W]);
         mv_in[l] = neg ? -mv_mag : mv_mag;
      end
      d_side = (LWH_W+1)'(s5_whl_ff[WHL_FL]) - (LWH_W+1)'(s5_whl_ff[WHL_BL]);
      d_turn = (LWH_W+1)'(s5_whl_ff[WHL_BL]) - (LWH_W+1)'(s5_whl_ff[WHL_FR]);
      // Halve, truncating toward zero
      h_side = (d_side + (LWH_W+1)'($signed({1'b0, d_side[LWH_W]}))) >>> 1;
      h_turn = (d_turn + (LWH_W+1)'($signed({1'b0, d_turn[LWH_W]}))) >>> 1;
      fwd_x  = (LWH_W+2)'(s5_whl_ff[WHL_FL]) - (LWH_W+2)'(h_side)
               - (LWH_W+2)'(h_turn);
      side_in = h_side[APP_W-1:0];
      turn_in = h_turn[APP_W-1:0];
      fwd_in  = fwd_x[APP_W-1:0];
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_WHEELS; l++) begin
         s1_whl_ff[l] <= s1_whl_in[l];
         s2_mag_ff[l] <= s2_mag_in[l];
         s2_alt_ff[l] <= s2_alt_in[l];
         s3_mag_ff[l] <= s2_mag_ff[l];
         s3_alt_ff[l] <= s2_alt_ff[l];
         s5_whl_ff[l] <= s5_whl_in[l];
      end
      s2_neg_ff   <= s2_neg_in;
      s2_lim_ff   <= s2_lim_in;
      s3_neg_ff   <= s2_neg_ff;
      s3_lim_ff   <= s2_lim_ff;
      s3_max_ff   <= s3_max_in;
      s3_scale_ff <= s3_scale_in;

      // Load the divider
      for (int l = 0; l < NUM_WHEELS; l++) begin
         dv_rem_ff[0][l] <= dv_rem_in[0][l];
         dv_quo_ff[0][l] <= dv_quo_in[0][l];
         dv_alt_ff[0][l] <= s3_alt_ff[l];
      end
      dv_den_ff[0]   <= s3_max_ff;
      dv_neg_ff[0]   <= s3_neg_ff;
      dv_scale_ff[0] <= s3_scale_ff;

      // Advance the divider stages
      for (int k = 0; k < QUO_W; k++) begin
         for (int l = 0; l < NUM_WHEELS; l++) begin
            dv_rem_ff[k+1][l] <= dv_rem_in[k+1][l];
            dv_quo_ff[k+1][l] <= dv_quo_in[k+1][l];
            dv_alt_ff[k+1][l] <= dv_alt_ff[k][l];
         end
         dv_den_ff[k+1]   <= dv_den_ff[k];
         dv_neg_ff[k+1]   <= dv_neg_ff[k];
         dv_scale_ff[k+1] <= dv_scale_ff[k];
      end

      // Result registers
      rsp_front_left_mv   <= mv_in[WHL_FL];
      rsp_front_right_mv  <= mv_in[WHL_FR];
      rsp_back_left_mv    <= mv_in[WHL_BL];
      rsp_back_right_mv   <= mv_in[WHL_BR];
      rsp_applied_forward <= fwd_in;
      rsp_applied_strafe  <= side_in;
      rsp_applied_rotate  <= turn_in;
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

endmodule

`default_nettype wire

@@ tb/holonomic_wheel_mixer_core_test.sv @@
`timescale 1ns / 1ps

module holonomic_wheel_mixer_core_test;
   import hwm_pkg::*;

   localparam int LATENCY        = 21;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int NEAR_FULL      = FULL_Q88 / 3;

   typedef struct {
      logic signed [MV_W-1:0]  fl_mv;
      logic signed [MV_W-1:0]  fr_mv;
      logic signed [MV_W-1:0]  bl_mv;
      logic signed [MV_W-1:0]  br_mv;
      logic signed [APP_W-1:0] forward;
      logic signed [APP_W-1:0] strafe;
      logic signed [APP_W-1:0] rotate;
   } wheel_drive_type;

   // Mirror of the mixer: register copy, expected drives in request order
   class drive_scoreboard;
      int              speed_limit;
      logic            limit_mode;
      wheel_drive_type pending_drives[$];
      int              errors;
      int              compared;

      function new();
         speed_limit = PCT_MAX;
         limit_mode  = LIMIT_SCALE;
         errors      = 0;
         compared    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] value);
         if (index == CSR_SPEED_LIMIT) begin
            speed_limit = value;
         end else begin
            limit_mode = value[0];
         end
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Mix, limit, convert to millivolts and recover the drive signal
      function wheel_drive_type mix_drive(logic signed [CMD_W-1:0] f,
                                          logic signed [CMD_W-1:0] s,
                                          logic signed [CMD_W-1:0] r);
         longint          w [NUM_WHEELS];
         longint          mv [NUM_WHEELS];
         longint          lim;
         longint          peak;
         longint          side;
         longint          turn;
         wheel_drive_type d;
         w[WHL_FL] = longint'(f) + s + r;
         w[WHL_FR] = longint'(f) - s - r;
         w[WHL_BL] = longint'(f) - s + r;
         w[WHL_BR] = longint'(f) + s - r;
         if (limit_mode == LIMIT_SCALE) begin
            lim  = longint'((speed_limit > PCT_MAX) ? PCT_MAX : speed_limit) * 256;
            peak = 0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
               if (((w[i] < 0) ? -w[i] : w[i]) > peak) peak = (w[i] < 0) ? -w[i] : w[i];
            end
            // signed division truncates toward zero, as the scaling requires
            if (peak != 0 && peak > lim) begin
               for (int i = 0; i < NUM_WHEELS; i++) w[i] = w[i] * lim / peak;
            end
         end else begin
            for (int i = 0; i < NUM_WHEELS; i++) w[i] = clip(w[i], -FULL_Q88, FULL_Q88);
         end
         for (int i = 0; i < NUM_WHEELS; i++) begin
            mv[i] = clip(w[i] * MV_PER_PCT / 256, -16384, 16383);
         end
         side = (w[WHL_FL] - w[WHL_BL]) / 2;
         turn = (w[WHL_BL] - w[WHL_FR]) / 2;
         d.fl_mv   = mv[WHL_FL];
         d.fr_mv   = mv[WHL_FR];
         d.bl_mv   = mv[WHL_BL];
         d.br_mv   = mv[WHL_BR];
         d.forward = clip(w[WHL_FL] - side - turn, -32768, 32767);
         d.strafe  = clip(side, -32768, 32767);
         d.rotate  = clip(turn, -32768, 32767);
         return d;
      endfunction

      function void note_command(logic signed [CMD_W-1:0] f,
                                 logic signed [CMD_W-1:0] s,
                                 logic signed [CMD_W-1:0] r);
         pending_drives.push_back(mix_drive(f, s, r));
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_drive(wheel_drive_type got);
         wheel_drive_type want;
         if (pending_drives.size() == 0) begin
            errors++;
            $display("%0t: drive result with no request waiting, expected none, got fl %0d",
                     $time, got.fl_mv);
            return;
         end
         want = pending_drives.pop_front();
         compared++;
         compare_field("front_left_mv", want.fl_mv, got.fl_mv);
         compare_field("front_right_mv", want.fr_mv, got.fr_mv);
         compare_field("back_left_mv", want.bl_mv, got.bl_mv);
         compare_field("back_right_mv", want.br_mv, got.br_mv);
         compare_field("applied_forward", want.forward, got.forward);
         compare_field("applied_strafe", want.strafe, got.strafe);
         compare_field("applied_rotate", want.rotate, got.rotate);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CMD_W-1:0] req_forward_cmd = '0;
   logic signed [CMD_W-1:0] req_strafe_cmd  = '0;
   logic signed [CMD_W-1:0] req_rotate_cmd  = '0;
   logic rsp_valid;
   logic signed [MV_W-1:0]  rsp_front_left_mv;
   logic signed [MV_W-1:0]  rsp_front_right_mv;
   logic signed [MV_W-1:0]  rsp_back_left_mv;
   logic signed [MV_W-1:0]  rsp_back_right_mv;
   logic signed [APP_W-1:0] rsp_applied_forward;
   logic signed [APP_W-1:0] rsp_applied_strafe;
   logic signed [APP_W-1:0] rsp_applied_rotate;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SPEED_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   drive_scoreboard sb = new();
   bit idling_on   = 1'b1;
   int sent        = 0;
   int settings    = 0;
   int idle_cycles = 0;

   holonomic_wheel_mixer_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_forward_cmd     (req_forward_cmd),
      .req_strafe_cmd      (req_strafe_cmd),
      .req_rotate_cmd      (req_rotate_cmd),
      .rsp_valid           (rsp_valid),
      .rsp_front_left_mv   (rsp_front_left_mv),
      .rsp_front_right_mv  (rsp_front_right_mv),
      .rsp_back_left_mv    (rsp_back_left_mv),
      .rsp_back_right_mv   (rsp_back_right_mv),
      .rsp_applied_forward (rsp_applied_forward),
      .rsp_applied_strafe  (rsp_applied_strafe),
      .rsp_applied_rotate  (rsp_applied_rotate),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check results before noting the request taken at the same edge
   always @(posedge clock) begin
      wheel_drive_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got.fl_mv   = rsp_front_left_mv;
            got.fr_mv   = rsp_front_right_mv;
            got.bl_mv   = rsp_back_left_mv;
            got.br_mv   = rsp_back_right_mv;
            got.forward = rsp_applied_forward;
            got.strafe  = rsp_applied_strafe;
            got.rotate  = rsp_applied_rotate;
            sb.check_drive(got);
         end
         if (start && !busy) begin
            sb.note_command(req_forward_cmd, req_strafe_cmd, req_rotate_cmd);
         end
         // Watchdog: count edges that move nothing
         if (rsp_valid || (start && !busy)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d drives still expected",
                     $time, sb.pending_drives.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Write both registers on consecutive edges, then drop the enable
   task automatic configure(input int limit, input logic mode);
      logic [CSR_DATA_W-1:0] mode_word;
      mode_word = {6'($urandom_range(0, 63)), mode};
      csr_we    <= 1'b1;
      csr_index <= CSR_SPEED_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(posedge clock);
      sb.set_register(CSR_SPEED_LIMIT, CSR_DATA_W'(limit));
      csr_index <= CSR_LIMIT_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      sb.set_register(CSR_LIMIT_MODE, mode_word);
      csr_we <= 1'b0;
      settings++;
   endtask

   // Present one request, hold it until taken, then maybe idle
   task automatic send_command(input logic signed [CMD_W-1:0] f,
                               input logic signed [CMD_W-1:0] s,
                               input logic signed [CMD_W-1:0] r);
      start           <= 1'b1;
      req_forward_cmd <= f;
      req_strafe_cmd  <= s;
      req_rotate_cmd  <= r;
      do @(posedge clock); while (busy);
      sent++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   function automatic logic signed [CMD_W-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random();
      int lim_q;
      int s;
      int r;
      int sign;
      case ($urandom_range(0, 3))
         0: send_command($urandom, $urandom, $urandom);
         1: send_command(int'($urandom_range(0, 2 * NEAR_FULL)) - NEAR_FULL,
                         int'($urandom_range(0, 2 * NEAR_FULL)) - NEAR_FULL,
                         int'($urandom_range(0, 2 * NEAR_FULL)) - NEAR_FULL);
         2: begin
            // front left wheel lands just around the active limit
            lim_q = (sb.limit_mode == LIMIT_CLAMP) ? FULL_Q88
                  : ((sb.speed_limit > PCT_MAX) ? PCT_MAX : sb.speed_limit) * 256;
            s     = int'($urandom_range(0, 128)) - 64;
            r     = int'($urandom_range(0, 128)) - 64;
            sign  = $urandom_range(0, 1) ? 1 : -1;
            send_command(sign * lim_q + int'($urandom_range(0, 8)) - 4 - s - r, s, r);
         end
         default: send_command(pick_extreme(), pick_extreme(), pick_extreme());
      endcase
   endtask

   // Drop start and wait until every expected drive has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_drives.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int limit, input logic mode, input int count);
      configure(limit, mode);
      repeat (count) send_random();
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands at reset settings
      configure(PCT_MAX, LIMIT_SCALE);
      send_command(0, 0, 0);
      send_command(32767, 32767, 32767);
      send_command(-32768, -32768, -32768);
      send_command(32767, 0, 0);
      send_command(0, 32767, 0);
      send_command(0, 0, 32767);
      send_command(-32768, 0, 0);
      send_command(0, -32768, 0);
      send_command(0, 0, -32768);
      send_command(25600, 0, 0);
      send_command(25601, 0, 0);
      send_command(8533, 8533, 8534);
      send_command(1, 0, 0);
      send_command(-1, 0, 0);
      send_command(-3, 1, 0);
      send_command(32767, -32768, 32767);
      send_command(-32768, 32767, -32768);
      send_command(100, -50, 25);
      send_command(256, 0, 0);
      repeat (30) send_random();
      drain();

      // Zero limit, limit above range, tiny and mid limits, then clamp mode
      run_phase(0, LIMIT_SCALE, 50);
      run_phase(127, LIMIT_SCALE, 50);
      run_phase(1, LIMIT_SCALE, 50);
      run_phase($urandom_range(2, 99), LIMIT_SCALE, 50);
      run_phase($urandom_range(0, 127), LIMIT_CLAMP, 50);
      run_phase(0, LIMIT_CLAMP, 50);

      // Back-to-back requests to close out the run
      idling_on = 1'b0;
      run_phase($urandom_range(50, 100), LIMIT_SCALE, 60);

      repeat (LATENCY + 4) @(posedge clock);
      $display("Mixed %0d commands over %0d register settings in scale and clamp modes",
               sent, settings);
      $display("Compared %0d wheel drive results, %0d field mismatches",
               sb.compared, sb.errors);
      if (sb.errors == 0 && sb.pending_drives.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/hwm_pkg.sv
rtl/holonomic_wheel_mixer_core.sv
tb/holonomic_wheel_mixer_core_test.sv
